/* rtl/shp_pkg.sv */
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants for the signature hit predictor replacement block.
// ----------------------------------------------------------------------------
package shp_pkg;

	localparam int SET_IDX_W = 11;
	localparam int WAY_IN_W  = 4;
	localparam int PC_W      = 10;

	localparam int NUM_SETS_DEF    = 2048;
	localparam int NUM_WAYS_DEF    = 16;
	localparam int SIG_ENTRIES_DEF = 1024;

	localparam int AGE_BITS = 2;
	localparam int CTR_BITS = 2;

	localparam logic [AGE_BITS-1:0] AGE_MAX  = AGE_BITS'((1 << AGE_BITS) - 1);
	localparam logic [AGE_BITS-1:0] AGE_COLD = AGE_MAX - 1'b1;
	localparam logic [AGE_BITS-1:0] AGE_HOT  = '0;
	localparam logic [CTR_BITS-1:0] CTR_MAX  = CTR_BITS'((1 << CTR_BITS) - 1);
	localparam logic [CTR_BITS-1:0] CTR_INIT = CTR_BITS'(1);
	localparam logic [CTR_BITS-1:0] CTR_HOT  = CTR_BITS'((CTR_MAX + 1) / 2);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_TRAIN
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic ctr_rd;
		logic row_commit;
		logic train_commit;
	} ctrl_t;

	typedef struct packed {
		logic clr_last;
		logic needs_train;
	} stat_t;

endpackage

/* rtl/shp_req_if.sv */
// ----------------------------------------------------------------------------
// shp_req_if
// Access request channel: set, hit flag, hit way and program counter bits.
// ----------------------------------------------------------------------------
interface shp_req_if;

	logic                          valid;
	logic                          ready;
	logic [shp_pkg::SET_IDX_W-1:0] set_index;
	logic                          hit;
	logic [shp_pkg::WAY_IN_W-1:0]  hit_way;
	logic [shp_pkg::PC_W-1:0]      pc_bits;

	modport source (output valid, set_index, hit, hit_way, pc_bits, input ready);
	modport sink (input valid, set_index, hit, hit_way, pc_bits, output ready);

endinterface

/* rtl/shp_rsp_if.sv */
// ----------------------------------------------------------------------------
// shp_rsp_if
// Replacement result channel: chosen way and hot insertion flag.
// ----------------------------------------------------------------------------
interface shp_rsp_if;

	logic                         valid;
	logic                         ready;
	logic [shp_pkg::WAY_IN_W-1:0] chosen_way;
	logic                         inserted_hot;

	modport source (output valid, chosen_way, inserted_hot, input ready);
	modport sink (input valid, chosen_way, inserted_hot, output ready);

endinterface

/* rtl/shp_ctrl.sv */
// ----------------------------------------------------------------------------
// shp_ctrl
// Sequencer for table clearing, row read-modify-write and counter training.
// ----------------------------------------------------------------------------
module shp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  shp_pkg::stat_t stat,
	output shp_pkg::ctrl_t ctrl
);

	shp_pkg::state_t state_q;
	shp_pkg::state_t state_d;
	logic            rsp_valid_q;
	logic            slot_free;
	logic            load;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign load      = ctrl.row_commit || ctrl.train_commit;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shp_pkg::ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		req_ready = 1'b0;
		unique case (state_q)
			shp_pkg::ST_CLEAR: begin
				ctrl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = shp_pkg::ST_IDLE;
				end
			end
			shp_pkg::ST_IDLE: begin
				req_ready    = 1'b1;
				ctrl.capture = req_valid;
				if (req_valid) begin
					state_d = shp_pkg::ST_ROW;
				end
			end
			shp_pkg::ST_ROW: begin
				if (stat.needs_train) begin
					ctrl.ctr_rd = 1'b1;
					state_d     = shp_pkg::ST_TRAIN;
				end else if (slot_free) begin
					ctrl.row_commit = 1'b1;
					state_d         = shp_pkg::ST_IDLE;
				end
			end
			shp_pkg::ST_TRAIN: begin
				if (slot_free) begin
					ctrl.train_commit = 1'b1;
					state_d           = shp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shp_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_capture_to_row: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |=> state_q == shp_pkg::ST_ROW)
		else $error("accepted transaction did not move to row stage");

	a_train_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == shp_pkg::ST_TRAIN |->
			($past(state_q) == shp_pkg::ST_ROW || $past(state_q) == shp_pkg::ST_TRAIN))
		else $error("training stage entered without a row read");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("result loaded over an untaken transaction");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == shp_pkg::ST_CLEAR |-> !req_ready)
		else $error("request accepted during clearing pass");
`endif

endmodule

/* rtl/shp_dpath.sv */
// ----------------------------------------------------------------------------
// shp_dpath
// Age, reuse and signature rows per set, hit counter table, victim selection.
// ----------------------------------------------------------------------------
module shp_dpath #(
	parameter int NUM_SETS    = shp_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS    = shp_pkg::NUM_WAYS_DEF,
	parameter int SIG_ENTRIES = shp_pkg::SIG_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shp_pkg::ctrl_t                ctrl,
	output shp_pkg::stat_t                stat,
	input  logic [shp_pkg::SET_IDX_W-1:0] set_index,
	input  logic                          hit,
	input  logic [shp_pkg::WAY_IN_W-1:0]  hit_way,
	input  logic [shp_pkg::PC_W-1:0]      pc_bits,
	output logic [shp_pkg::WAY_IN_W-1:0]  chosen_way,
	output logic                          inserted_hot
);

	localparam int AW      = shp_pkg::AGE_BITS;
	localparam int CW      = shp_pkg::CTR_BITS;
	localparam int PW      = shp_pkg::PC_W;
	localparam int WIW     = shp_pkg::WAY_IN_W;
	localparam int SET_AW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W   = $clog2(NUM_WAYS);
	localparam int SIG_W   = $clog2(SIG_ENTRIES);
	localparam int CLR_LEN = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
	localparam int CLR_W   = $clog2(CLR_LEN);
	localparam int PC_MAX  = (1 << PW) - 1;

	logic [NUM_WAYS-1:0][AW-1:0]    age_mem [NUM_SETS];
	logic [NUM_WAYS-1:0]            reu_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][SIG_W-1:0] sig_mem [NUM_SETS];
	logic [CW-1:0]                  ctr_mem [SIG_ENTRIES];

	logic [CLR_W-1:0]               clr_q;
	logic                           clr_rows;
	logic                           clr_ctrs;

	logic                           set_in_ok;
	logic [SET_AW-1:0]              set_in_addr;
	logic [PW-1:0]                  pc_rem;
	logic [SIG_W-1:0]               sig_in;

	logic                           set_ok_q;
	logic                           hit_q;
	logic                           way_ok_q;
	logic [WIW-1:0]                 hit_way_q;
	logic [SET_AW-1:0]              set_q;
	logic [SIG_W-1:0]               sig_q;

	logic [NUM_WAYS-1:0][AW-1:0]    age_rd_q;
	logic [NUM_WAYS-1:0]            reu_rd_q;
	logic [NUM_WAYS-1:0][SIG_W-1:0] sig_rd_q;

	logic [AW-1:0]                  oldest;
	logic [AW-1:0]                  lift;
	logic [NUM_WAYS-1:0][AW-1:0]    aged;
	logic [WAY_W-1:0]               victim;
	logic [SIG_W-1:0]               old_sig;

	logic [NUM_WAYS-1:0][AW-1:0]    aged_q;
	logic [WAY_W-1:0]               victim_q;
	logic [SIG_W-1:0]               old_sig_q;
	logic                           old_reu_q;
	logic [CW-1:0]                  ctr_old_q;
	logic [CW-1:0]                  ctr_new_q;

	logic [CW-1:0]                  trained;
	logic [CW-1:0]                  new_ctr;
	logic                           hot;

	logic                           row_we;
	logic [SET_AW-1:0]              row_addr;
	logic [NUM_WAYS-1:0][AW-1:0]    age_wr;
	logic [NUM_WAYS-1:0]            reu_wr;
	logic [NUM_WAYS-1:0][SIG_W-1:0] sig_wr;
	logic                           ctr_we;
	logic [SIG_W-1:0]               ctr_addr;
	logic [CW-1:0]                  ctr_wr;
	logic [WAY_W-1:0]               hit_idx;

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctrl.clr_wr && !stat.clr_last) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign stat.clr_last    = (clr_q == CLR_W'(CLR_LEN - 1));
	assign stat.needs_train = set_ok_q && !hit_q;
	assign clr_rows         = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_SETS));
	assign clr_ctrs         = ({1'b0, clr_q} < (CLR_W + 1)'(SIG_ENTRIES));

	// request decode, signature by repeated compare and subtract
	assign set_in_ok   = (17'(set_index) < 17'(NUM_SETS));
	assign set_in_addr = SET_AW'(set_index);

	always_comb begin
		pc_rem = pc_bits;
		for (int k = PW - 1; k >= 0; k--) begin
			if (SIG_ENTRIES * (2 ** k) <= PC_MAX) begin
				if (pc_rem >= PW'(SIG_ENTRIES * (2 ** k))) begin
					pc_rem = pc_rem - PW'(SIG_ENTRIES * (2 ** k));
				end
			end
		end
	end

	assign sig_in = SIG_W'(pc_rem);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			set_ok_q  <= set_in_ok;
			hit_q     <= hit;
			way_ok_q  <= (6'(hit_way) < 6'(NUM_WAYS));
			hit_way_q <= hit_way;
			set_q     <= set_in_addr;
			sig_q     <= sig_in;
			if (set_in_ok) begin
				age_rd_q <= age_mem[set_in_addr];
				reu_rd_q <= reu_mem[set_in_addr];
				sig_rd_q <= sig_mem[set_in_addr];
			end
		end
	end

	// victim selection after aging
	always_comb begin
		logic [3:0] seen;
		seen = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			seen[age_rd_q[w]] = 1'b1;
		end
		if (seen[3]) begin
			oldest = AW'(3);
		end else if (seen[2]) begin
			oldest = AW'(2);
		end else if (seen[1]) begin
			oldest = AW'(1);
		end else begin
			oldest = '0;
		end
		lift = shp_pkg::AGE_MAX - oldest;
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged[w] = age_rd_q[w] + lift;
		end
		victim = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (aged[w] == shp_pkg::AGE_MAX) begin
				victim = WAY_W'(w);
			end
		end
	end

	assign old_sig = sig_rd_q[victim];

	always_ff @(posedge clk) begin
		if (ctrl.ctr_rd) begin
			aged_q    <= aged;
			victim_q  <= victim;
			old_sig_q <= old_sig;
			old_reu_q <= reu_rd_q[victim];
			ctr_old_q <= ctr_mem[old_sig];
			ctr_new_q <= ctr_mem[sig_q];
		end
	end

	// counter training
	always_comb begin
		if (old_reu_q) begin
			trained = (ctr_old_q == shp_pkg::CTR_MAX) ? ctr_old_q : ctr_old_q + 1'b1;
		end else begin
			trained = (ctr_old_q == '0) ? ctr_old_q : ctr_old_q - 1'b1;
		end
		new_ctr = (sig_q == old_sig_q) ? trained : ctr_new_q;
		hot     = (new_ctr >= shp_pkg::CTR_HOT);
	end

	assign hit_idx = WAY_W'(hit_way_q);

	// row write data
	always_comb begin
		row_we   = 1'b0;
		row_addr = set_q;
		age_wr   = age_rd_q;
		reu_wr   = reu_rd_q;
		sig_wr   = sig_rd_q;
		if (ctrl.clr_wr) begin
			row_we   = clr_rows;
			row_addr = SET_AW'(clr_q);
			for (int w = 0; w < NUM_WAYS; w++) begin
				age_wr[w] = shp_pkg::AGE_MAX;
			end
			reu_wr = '0;
			sig_wr = '0;
		end else if (ctrl.row_commit) begin
			row_we           = set_ok_q && hit_q && way_ok_q;
			age_wr[hit_idx]  = shp_pkg::AGE_HOT;
			reu_wr[hit_idx]  = 1'b1;
		end else if (ctrl.train_commit) begin
			row_we           = 1'b1;
			age_wr           = aged_q;
			age_wr[victim_q] = hot ? shp_pkg::AGE_HOT : shp_pkg::AGE_COLD;
			reu_wr[victim_q] = 1'b0;
			sig_wr[victim_q] = sig_q;
		end
	end

	always_comb begin
		ctr_we   = 1'b0;
		ctr_addr = old_sig_q;
		ctr_wr   = trained;
		if (ctrl.clr_wr) begin
			ctr_we   = clr_ctrs;
			ctr_addr = SIG_W'(clr_q);
			ctr_wr   = shp_pkg::CTR_INIT;
		end else if (ctrl.train_commit) begin
			ctr_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			age_mem[row_addr] <= age_wr;
			reu_mem[row_addr] <= reu_wr;
			sig_mem[row_addr] <= sig_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_we) begin
			ctr_mem[ctr_addr] <= ctr_wr;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.row_commit) begin
			chosen_way   <= set_ok_q ? hit_way_q : '0;
			inserted_hot <= 1'b0;
		end else if (ctrl.train_commit) begin
			chosen_way   <= WIW'(victim_q);
			inserted_hot <= hot;
		end
	end

`ifndef SYNTHESIS
	a_victim_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ctr_rd |-> aged[victim] == shp_pkg::AGE_MAX)
		else $error("victim way is not at maximum age");

	a_hot_only_on_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.row_commit |=> !inserted_hot)
		else $error("hot flag set on a hit or ignored transaction");

	a_clear_counter_stops: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.clr_wr |=> $stable(clr_q))
		else $error("clear address moved outside clearing pass");
`endif

endmodule

/* rtl/signature_hit_predictor_replacement_top.sv */
// ----------------------------------------------------------------------------
// signature_hit_predictor_replacement_top
// Cache replacement policy: 2-bit re-reference ages per line with a table of
// saturating hit counters indexed by a program counter signature.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one access per transaction (set_index, hit, hit_way, pc_bits);
//   rsp returns exactly one result per access (chosen_way, inserted_hot).
//   A hit, or an access to a set out of range, gives its result from the row
//   stage after acceptance; a miss passes a further training stage, entered
//   with the hit counter table read for training. Requests are taken one at
//   a time: a new request is not taken until the previous result has been
//   loaded into the output register, which rsp stalls can delay.
//   The result sits in an output register, so a new request is taken while the
//   previous result still waits; when rsp stalls, the next result is held in
//   its final stage until the output register frees.
//   After reset a clearing pass over max(NUM_SETS, SIG_ENTRIES) addresses (2048
//   at the defaults) sets all ages to 3, signatures and reuse marks to 0, and all
//   counters to 1; req.ready stays low during the pass.
// ----------------------------------------------------------------------------
module signature_hit_predictor_replacement_top #(
	parameter int NUM_SETS    = shp_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS    = shp_pkg::NUM_WAYS_DEF,
	parameter int SIG_ENTRIES = shp_pkg::SIG_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	shp_req_if.sink   req,
	shp_rsp_if.source rsp
);

	shp_pkg::ctrl_t ctrl;
	shp_pkg::stat_t stat;

	shp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	shp_dpath #(
		.NUM_SETS    (NUM_SETS),
		.NUM_WAYS    (NUM_WAYS),
		.SIG_ENTRIES (SIG_ENTRIES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.set_index    (req.set_index),
		.hit          (req.hit),
		.hit_way      (req.hit_way),
		.pc_bits      (req.pc_bits),
		.chosen_way   (rsp.chosen_way),
		.inserted_hot (rsp.inserted_hot)
	);

endmodule

/* tb/tb_signature_hit_predictor_replacement_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signature_hit_predictor_replacement_top
// Self-checking bench for the signature hit predictor replacement block. A
// scoreboard class keeps its own copy of the per-line ages, signatures and
// reuse marks and of the signature counter table. From each accepted access it
// works out the victim or hit way and the hot insertion flag, and checks them
// against the results in order. The stimulus starts with a short directed
// sequence. Random accesses follow, mostly on a few sets and program counters
// so that counters train both ways, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_signature_hit_predictor_replacement_top;

	localparam int NSETS      = shp_pkg::NUM_SETS_DEF;
	localparam int NWAYS      = shp_pkg::NUM_WAYS_DEF;
	localparam int NSIG       = shp_pkg::SIG_ENTRIES_DEF;
	localparam int NLINES     = NSETS * NWAYS;
	localparam int RAND_ITEMS = 700;
	localparam int CYCLE_CAP  = 200000;

	typedef struct packed {
		logic [shp_pkg::WAY_IN_W-1:0] way;
		logic                         hot;
	} repl_result_t;

	class repl_scoreboard;
		logic [shp_pkg::AGE_BITS-1:0] age_of    [NLINES];
		logic [shp_pkg::PC_W-1:0]     sig_of    [NLINES];
		logic                         reused_of [NLINES];
		logic [shp_pkg::CTR_BITS-1:0] ctr_of    [NSIG];
		repl_result_t                 awaited[$];
		int                           errors;
		int                           checked;
		int                           accesses;
		int                           misses;
		int                           hot_fills;

		function new();
			for (int i = 0; i < NLINES; i++) begin
				age_of[i]    = shp_pkg::AGE_MAX;
				sig_of[i]    = '0;
				reused_of[i] = 1'b0;
			end
			for (int i = 0; i < NSIG; i++) begin
				ctr_of[i] = shp_pkg::CTR_INIT;
			end
			errors    = 0;
			checked   = 0;
			accesses  = 0;
			misses    = 0;
			hot_fills = 0;
		endfunction

		function void note_access(logic [shp_pkg::SET_IDX_W-1:0] set_index, logic hit_flag,
				logic [shp_pkg::WAY_IN_W-1:0] hit_way, logic [shp_pkg::PC_W-1:0] pc);
			repl_result_t                 res;
			int                           base;
			int                           line;
			int                           victim;
			int                           sig;
			int                           old_sig;
			logic [shp_pkg::AGE_BITS-1:0] oldest;
			logic [shp_pkg::AGE_BITS-1:0] lift;
			res = '0;
			accesses++;
			if (set_index >= NSETS) begin
				awaited.push_back(res);
				return;
			end
			base = set_index * NWAYS;
			if (hit_flag) begin
				res.way = hit_way;
				if (hit_way < NWAYS) begin
					age_of[base + hit_way]    = shp_pkg::AGE_HOT;
					reused_of[base + hit_way] = 1'b1;
				end
				awaited.push_back(res);
				return;
			end
			misses++;
			// age the row until some way reaches the maximum
			oldest = '0;
			for (int w = 0; w < NWAYS; w++) begin
				if (age_of[base + w] > oldest)
					oldest = age_of[base + w];
			end
			lift = shp_pkg::AGE_MAX - oldest;
			for (int w = 0; w < NWAYS; w++) begin
				age_of[base + w] = age_of[base + w] + lift;
			end
			victim = 0;
			for (int w = NWAYS - 1; w >= 0; w--) begin
				if (age_of[base + w] == shp_pkg::AGE_MAX)
					victim = w;
			end
			line    = base + victim;
			old_sig = sig_of[line] % NSIG;
			// train the evicted line's counter
			if (reused_of[line]) begin
				if (ctr_of[old_sig] != shp_pkg::CTR_MAX)
					ctr_of[old_sig] = ctr_of[old_sig] + 1'b1;
			end else begin
				if (ctr_of[old_sig] != '0)
					ctr_of[old_sig] = ctr_of[old_sig] - 1'b1;
			end
			sig             = pc % NSIG;
			sig_of[line]    = shp_pkg::PC_W'(sig);
			reused_of[line] = 1'b0;
			if (ctr_of[sig] >= shp_pkg::CTR_HOT) begin
				age_of[line] = shp_pkg::AGE_HOT;
				res.hot      = 1'b1;
				hot_fills++;
			end else begin
				age_of[line] = shp_pkg::AGE_COLD;
			end
			res.way = shp_pkg::WAY_IN_W'(victim);
			awaited.push_back(res);
		endfunction

		function void check_result(logic [shp_pkg::WAY_IN_W-1:0] way, logic hot);
			repl_result_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result transaction: chosen_way %0d, inserted_hot %0d",
					way, hot);
				errors++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (way !== want.way) begin
				$error("chosen_way mismatch: expected %0d, actual %0d", want.way, way);
				errors++;
			end
			if (hot !== want.hot) begin
				$error("inserted_hot mismatch: expected %0d, actual %0d", want.hot, hot);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic steady;
	int   cycles;

	repl_scoreboard sb;

	shp_req_if req_ch();
	shp_rsp_if rsp_ch();

	signature_hit_predictor_replacement_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// request monitor
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_access(req_ch.set_index, req_ch.hit, req_ch.hit_way, req_ch.pc_bits);
	end

	// result monitor and backpressure
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.chosen_way, rsp_ch.inserted_hot);
		rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
	end

	task automatic send_access(input logic [shp_pkg::SET_IDX_W-1:0] set_index,
			input logic hit_flag, input logic [shp_pkg::WAY_IN_W-1:0] hit_way,
			input logic [shp_pkg::PC_W-1:0] pc);
		while (!steady && $urandom_range(0, 99) < 29) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.set_index <= set_index;
		req_ch.hit       <= hit_flag;
		req_ch.hit_way   <= hit_way;
		req_ch.pc_bits   <= pc;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic [shp_pkg::SET_IDX_W-1:0] set_pool [4];
		logic [shp_pkg::PC_W-1:0]      pc_pool  [8];
		int                            roll;
		sb                = new();
		cycles            = 0;
		steady            = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.set_index  = '0;
		req_ch.hit        = 1'b0;
		req_ch.hit_way    = '0;
		req_ch.pc_bits    = '0;
		rsp_ch.ready      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: fills at both ends of the set range, hits on end ways,
		// extreme and alternating program counters
		send_access(11'd0, 1'b0, 4'd0, 10'd0);
		send_access(11'd0, 1'b0, 4'd9, 10'd0);
		send_access(11'd0, 1'b0, 4'd0, 10'd0);
		send_access(11'd0, 1'b1, 4'd0, 10'd0);
		send_access(11'd0, 1'b1, 4'd15, 10'd1023);
		send_access(11'd0, 1'b0, 4'd15, 10'd1023);
		send_access(11'd0, 1'b0, 4'd0, 10'd1023);
		send_access(11'd2047, 1'b1, 4'd15, 10'd1023);
		send_access(11'd2047, 1'b0, 4'd5, 10'h155);
		send_access(11'd2047, 1'b0, 4'd10, 10'h2aa);
		send_access(11'h555, 1'b1, 4'd5, 10'h2aa);
		send_access(11'h2aa, 1'b1, 4'd10, 10'h155);
		send_access(11'd2047, 1'b1, 4'd15, 10'h155);
		send_access(11'd2047, 1'b0, 4'd0, 10'h155);
		send_access(11'd0, 1'b0, 4'd0, 10'd0);
		send_access(11'd0, 1'b1, 4'd1, 10'd0);
		drain_results();

		for (int i = 0; i < 4; i++)
			set_pool[i] = shp_pkg::SET_IDX_W'($urandom_range(0, NSETS - 1));
		for (int i = 0; i < 8; i++) pc_pool[i] = shp_pkg::PC_W'($urandom_range(0, 1023));

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2) begin
				drain_results();
				for (int i = 0; i < 4; i++)
					set_pool[i] = shp_pkg::SET_IDX_W'($urandom_range(0, NSETS - 1));
				for (int i = 0; i < 8; i++)
					pc_pool[i] = shp_pkg::PC_W'($urandom_range(0, 1023));
			end
			steady = (n >= 420 && n < 540);
			roll   = $urandom_range(0, 99);
			if (roll < 80)
				send_access(set_pool[$urandom_range(0, 3)], $urandom_range(0, 99) < 45,
					shp_pkg::WAY_IN_W'($urandom_range(0, NWAYS - 1)),
					pc_pool[$urandom_range(0, 7)]);
			else
				send_access(shp_pkg::SET_IDX_W'($urandom_range(0, NSETS - 1)), 1'($urandom),
					shp_pkg::WAY_IN_W'($urandom), shp_pkg::PC_W'($urandom));
		end
		steady = 1'b0;
		drain_results();
		repeat (10) @(posedge clk);

		$display("covered %0d accesses (%0d misses, %0d hot fills) over trained sets,",
			sb.accesses, sb.misses, sb.hot_fills);
		$display("%0d results checked with random gaps and stalls on both channels",
			sb.checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/shp_pkg.sv
rtl/shp_req_if.sv
rtl/shp_rsp_if.sv
rtl/shp_ctrl.sv
rtl/shp_dpath.sv
rtl/signature_hit_predictor_replacement_top.sv
tb/tb_signature_hit_predictor_replacement_top.sv
